>>> rtl/clt_pkg.sv
// Shared types, codes and character helpers for the command line tokenizer.
package clt_pkg;

  // Request opcodes
  localparam logic [1:0] OP_FEED = 2'd0;
  localparam logic [1:0] OP_EAT  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Event codes reported with each result
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_TOKEN = 2'd1;
  localparam logic [1:0] EV_ESC   = 2'd2;
  localparam logic [1:0] EV_OVF   = 2'd3;

  localparam logic [7:0] ESC_RESET = 8'd27;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT,
    ST_WRITE,
    ST_HEAD,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  // One result, packed from the highest field down to the lowest
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_char;
    logic       dropped_oldest;
    logic [1:0] event_res;
    logic [4:0] input_length;
    logic [3:0] token_count;
  } result_t;

  // Space and the 0x09..0x0D control range
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Upper-case a..z only
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

endpackage

>>> rtl/command_line_tokenizer.sv
// Command line tokenizer: top level with sequencer, slot ring and token stores.
// Sequence: ST_DECODE, then ST_SLOT with ST_WRITE or ST_READ and ST_CHECK, and ST_HEAD
// as needed; ST_DONE registers the result, waiting while the last one is unaccepted.
// One request at a time: the sequencer shares one slot adder and takes a new request only in ST_IDLE.
// Reset: token count, partial length, ring head and escape code (27) are set;
// token byte and length RAMs are left undefined and are never read unwritten.
module command_line_tokenizer #(
  parameter int MAX_TOKENS = 8,
  parameter int LINE_CHARS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: escape code
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_in[7:0], eat_count[11:8], token_index[14:12],
                                     // char_pos[19:15], zero[23:20]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // token_count[3:0], input_length[8:4], event_res[10:9],
                                     // dropped_oldest[11], read_char[19:12],
                                     // read_valid[20], zero[23:21]
);

  localparam int SLOTS = MAX_TOKENS + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_TOKENS + 1);
  localparam int LW    = $clog2(LINE_CHARS);
  localparam int DEPTH = SLOTS * LINE_CHARS;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer and control state
  clt_pkg::state_e state_q, state_d;
  logic [7:0]      esc_q;
  logic [SW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [LW-1:0]   plen_q, plen_d;
  logic            m_valid_q, m_valid_d;

  // Request payload and per-request working values
  logic [1:0]      op_q;
  logic [7:0]      char_q;
  logic [3:0]      eat_q;
  logic [2:0]      tidx_q;
  logic [4:0]      pos_q;
  logic [SW-1:0]   slot_q, slot_d;
  logic [1:0]      ev_q, ev_d;
  logic            drop_q, drop_d;
  logic [7:0]      rchar_q, rchar_d;
  logic            rvalid_q, rvalid_d;
  clt_pkg::result_t out_q, out_d;

  logic            s_accept;
  logic [CW-1:0]   eat_n;
  logic [SW-1:0]   alu_b;
  logic [SW-1:0]   alu_sum;
  logic [AW-1:0]   slot_base;
  logic            pos_in_line;
  logic [LW-1:0]   rd_off;

  // RAM ports
  logic            byte_we;
  logic [AW-1:0]   byte_waddr;
  logic [7:0]      byte_wdata;
  logic [AW-1:0]   byte_raddr;
  logic [7:0]      byte_rdata;
  logic            len_we;
  logic [LW-1:0]   len_rdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == clt_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // Leading tokens to remove, clamped to the stored count
  assign eat_n = (32'(eat_q) > 32'(count_q)) ? count_q : CW'(eat_q);

  // Byte addressing: slot row times line length plus offset
  assign slot_base   = AW'(32'(slot_q) * LINE_CHARS);
  assign pos_in_line = (32'(pos_q) < LINE_CHARS);
  assign rd_off      = pos_in_line ? LW'(pos_q) : '0;
  assign byte_waddr  = slot_base + AW'(plen_q);
  assign byte_raddr  = slot_base + AW'(rd_off);
  assign byte_wdata  = clt_pkg::to_upper(char_q);

  // Shared slot adder operand select
  always_comb begin
    case (state_q)
      clt_pkg::ST_SLOT: alu_b = (op_q == clt_pkg::OP_READ) ? SW'(tidx_q) : SW'(count_q);
      clt_pkg::ST_HEAD: alu_b = (op_q == clt_pkg::OP_EAT) ? SW'(eat_n) : SW'(1);
      default:          alu_b = SW'(count_q);
    endcase
  end

  clt_slot_add #(
    .SLOTS (SLOTS)
  ) u_slot_add (
    .base_i (head_q),
    .offs_i (alu_b),
    .sum_o  (alu_sum)
  );

  clt_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  clt_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (slot_q),
    .wdata_i (plen_q),
    .raddr_i (slot_q),
    .rdata_o (len_rdata)
  );

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    plen_d    = plen_q;
    slot_d    = slot_q;
    ev_d      = ev_q;
    drop_d    = drop_q;
    rchar_d   = rchar_q;
    rvalid_d  = rvalid_q;
    m_valid_d = m_valid_q;
    out_d     = out_q;
    byte_we   = 1'b0;
    len_we    = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      clt_pkg::ST_IDLE: begin
        if (s_accept) begin
          ev_d     = clt_pkg::EV_NONE;
          drop_d   = 1'b0;
          rchar_d  = 8'h00;
          rvalid_d = 1'b0;
          state_d  = clt_pkg::ST_DECODE;
        end
      end

      clt_pkg::ST_DECODE: begin
        case (op_q)
          clt_pkg::OP_FEED: begin
            if (char_q == esc_q) begin
              count_d = '0;
              plen_d  = '0;
              ev_d    = clt_pkg::EV_ESC;
              state_d = clt_pkg::ST_DONE;
            end else if (clt_pkg::is_blank(char_q) && (plen_q == '0)) begin
              state_d = clt_pkg::ST_DONE;
            end else begin
              state_d = clt_pkg::ST_SLOT;
            end
          end
          clt_pkg::OP_EAT: state_d = clt_pkg::ST_HEAD;
          clt_pkg::OP_READ: begin
            if (32'(tidx_q) < 32'(count_q)) begin
              rvalid_d = 1'b1;
              state_d  = clt_pkg::ST_SLOT;
            end else begin
              state_d = clt_pkg::ST_DONE;
            end
          end
          default: state_d = clt_pkg::ST_DONE;
        endcase
      end

      // Ring slot of the partial buffer or of the token being read
      clt_pkg::ST_SLOT: begin
        slot_d  = alu_sum;
        state_d = (op_q == clt_pkg::OP_READ) ? clt_pkg::ST_READ : clt_pkg::ST_WRITE;
      end

      clt_pkg::ST_WRITE: begin
        if (clt_pkg::is_blank(char_q)) begin
          // Partial slot becomes a token; full ring drops its front
          len_we  = 1'b1;
          plen_d  = '0;
          ev_d    = clt_pkg::EV_TOKEN;
          if (32'(count_q) == MAX_TOKENS) begin
            drop_d  = 1'b1;
            state_d = clt_pkg::ST_HEAD;
          end else begin
            count_d = count_q + CW'(1);
            state_d = clt_pkg::ST_DONE;
          end
        end else begin
          byte_we = 1'b1;
          if (({1'b0, plen_q} + (LW+1)'(1)) == (LW+1)'(LINE_CHARS)) begin
            count_d = '0;
            plen_d  = '0;
            ev_d    = clt_pkg::EV_OVF;
          end else begin
            plen_d = plen_q + LW'(1);
          end
          state_d = clt_pkg::ST_DONE;
        end
      end

      // Advance the ring head past removed tokens
      clt_pkg::ST_HEAD: begin
        head_d = alu_sum;
        if (op_q == clt_pkg::OP_EAT) begin
          count_d = count_q - eat_n;
        end
        state_d = clt_pkg::ST_DONE;
      end

      clt_pkg::ST_READ: state_d = clt_pkg::ST_CHECK;

      clt_pkg::ST_CHECK: begin
        rchar_d = (pos_in_line && (32'(pos_q) < 32'(len_rdata))) ? byte_rdata : 8'h00;
        state_d = clt_pkg::ST_DONE;
      end

      clt_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d.token_count    = 4'(count_q);
          out_d.input_length   = 5'(plen_q);
          out_d.event_res      = ev_q;
          out_d.dropped_oldest = drop_q;
          out_d.read_char      = rchar_q;
          out_d.read_valid     = rvalid_q;
          m_valid_d            = 1'b1;
          state_d              = clt_pkg::ST_IDLE;
        end
      end

      default: state_d = clt_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clt_pkg::ST_IDLE;
      esc_q     <= clt_pkg::ESC_RESET;
      head_q    <= '0;
      count_q   <= '0;
      plen_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      plen_q    <= plen_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        esc_q <= cfg_data_i;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q   <= s_axis_tuser;
      char_q <= s_axis_tdata[7:0];
      eat_q  <= s_axis_tdata[11:8];
      tidx_q <= s_axis_tdata[14:12];
      pos_q  <= s_axis_tdata[19:15];
    end
    slot_q   <= slot_d;
    ev_q     <= ev_d;
    drop_q   <= drop_d;
    rchar_q  <= rchar_d;
    rvalid_q <= rvalid_d;
    out_q    <= out_d;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_TOKENS)
    else $error("token count above store size");

  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(plen_q) < LINE_CHARS)
    else $error("partial length reached line limit");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < SLOTS)
    else $error("ring head out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == clt_pkg::ST_DONE))
    else $error("result raised outside completion step");

endmodule

>>> rtl/clt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/clt_slot_add.sv
// Shared modular adder over the token slot ring.
module clt_slot_add #(
  parameter int SLOTS = 9
) (
  input  logic [$clog2(SLOTS)-1:0] base_i,
  input  logic [$clog2(SLOTS)-1:0] offs_i,
  output logic [$clog2(SLOTS)-1:0] sum_o
);

  localparam int SW = $clog2(SLOTS);

  logic [SW:0] raw;
  logic [SW:0] wrapped;

  // Both operands are below SLOTS, so one conditional subtract wraps the sum
  assign raw     = {1'b0, base_i} + {1'b0, offs_i};
  assign wrapped = raw - (SW+1)'(SLOTS);
  assign sum_o   = (raw >= (SW+1)'(SLOTS)) ? wrapped[SW-1:0] : raw[SW-1:0];

endmodule
